>>> sv/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg
// Types, codes and helper functions shared by the rule range partition block.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int ADDR_W    = 32;
  localparam int PLEN_W    = 6;
  localparam int PORT_W    = 16;
  localparam int PROTO_W   = 8;
  localparam int SIZE_W    = 6;
  localparam int THR_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int ERR_W     = 2;
  localparam int CLS_W     = 2;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_SRC   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_DST   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_PROTO = 2'd3;

  localparam logic [CLS_W-1:0] CLS_BOTH = 2'd0;
  localparam logic [CLS_W-1:0] CLS_SRC  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_DST  = 2'd2;
  localparam logic [CLS_W-1:0] CLS_BIG  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DST_THR = 2'd1;

  localparam logic [THR_W-1:0]   THR_RESET   = 6'd16;
  localparam logic [PROTO_W-1:0] PROTO_EXACT = 8'hFF;
  localparam logic [PROTO_W-1:0] PROTO_ANY   = 8'h00;
  localparam logic [ADDR_W-1:0]  ADDR_ALL    = 32'hFFFFFFFF;
  localparam logic [PLEN_W-1:0]  MAX_PLEN    = 6'd32;
  localparam logic [SIZE_W-1:0]  FULL_SIZE   = 6'd32;

  typedef struct packed {
    logic [ADDR_W-1:0]  src_addr;
    logic [PLEN_W-1:0]  src_prefix_len;
    logic [ADDR_W-1:0]  dst_addr;
    logic [PLEN_W-1:0]  dst_prefix_len;
    logic [PORT_W-1:0]  sport_low;
    logic [PORT_W-1:0]  sport_high;
    logic [PORT_W-1:0]  dport_low;
    logic [PORT_W-1:0]  dport_high;
    logic [PROTO_W-1:0] proto_value;
    logic [PROTO_W-1:0] proto_match;
  } rule_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  src_low;
    logic [ADDR_W-1:0]  src_high;
    logic [ADDR_W-1:0]  dst_low;
    logic [ADDR_W-1:0]  dst_high;
    logic [PROTO_W-1:0] proto_low;
    logic [PROTO_W-1:0] proto_high;
    logic [SIZE_W-1:0]  src_size;
    logic [SIZE_W-1:0]  dst_size;
    logic [SIZE_W-1:0]  sport_size;
    logic [SIZE_W-1:0]  dport_size;
    logic [CLS_W-1:0]   subset_class;
    logic [ERR_W-1:0]   error_code;
  } result_t;

  typedef struct packed {
    logic [THR_W-1:0] src;
    logic [THR_W-1:0] dst;
  } thr_t;

  // whole leading octets kept for a prefix length
  function automatic logic [ADDR_W-1:0] prefix_keep(input logic [PLEN_W-1:0] plen);
    logic [ADDR_W-1:0] keep;
    case (plen) inside
      6'd0:           keep = '0;
      [6'd1:6'd8]:    keep = 32'hFF000000;
      [6'd9:6'd16]:   keep = 32'hFFFF0000;
      [6'd17:6'd24]:  keep = 32'hFFFFFF00;
      default:        keep = ADDR_ALL;
    endcase
    return keep;
  endfunction

  // number of significant bits
  function automatic logic [SIZE_W-1:0] bit_len(input logic [PORT_W-1:0] v);
    logic [SIZE_W-1:0] n;
    n = '0;
    for (int i = 0; i < PORT_W; i++) begin
      if (v[i]) n = SIZE_W'(i + 1);
    end
    return n;
  endfunction

endpackage

>>> sv/crp_if.sv
// ----------------------------------------------------------------------------
// crp_if
// Request, result and configuration channels of the rule range partition.
// ----------------------------------------------------------------------------
interface crp_rule_if;
  logic            valid;
  logic            ready;
  crp_pkg::rule_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface crp_result_if;
  logic             valid;
  logic             ready;
  crp_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface crp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [crp_pkg::CFG_IDX_W-1:0]    index;
  logic [crp_pkg::THR_W-1:0]        data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/crp_cfg.sv
// ----------------------------------------------------------------------------
// crp_cfg
// Threshold register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module crp_cfg (
  input  logic         clk,
  input  logic         rst,
  crp_cfg_if.sink      cfg,
  output crp_pkg::thr_t thr
);
  import crp_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.src <= THR_RESET;
      thr.dst <= THR_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SRC_THR: thr.src <= cfg.data;
        REG_DST_THR: thr.dst <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

>>> sv/classifier_rule_range_partition.sv
// ----------------------------------------------------------------------------
// classifier_rule_range_partition
// Turns a five-tuple rule into address, protocol and port ranges with sizes.
// ----------------------------------------------------------------------------
// Takes one rule per clock, while the result is not stalled, through three
// register stages: prefix to range and port differences, then size encoding
// and threshold compares, then classification and error masking into the
// output register. An accepted request moves through s1, s2 and the output
// register in that order before its result is presented on the result channel.
// Each stage holds its item while the next one is full; stages behind a
// stalled result keep moving into empty slots, and a bubble is filled at once.
module classifier_rule_range_partition (
  input  logic     clk,
  input  logic     rst,
  crp_rule_if.sink     rule,
  crp_result_if.source result,
  crp_cfg_if.sink      cfg
);
  import crp_pkg::*;

  typedef struct packed {
    logic [ERR_W-1:0]   err;
    logic [ADDR_W-1:0]  slo;
    logic [ADDR_W-1:0]  shi;
    logic [ADDR_W-1:0]  dlo;
    logic [ADDR_W-1:0]  dhi;
    logic [PROTO_W-1:0] plo;
    logic [PROTO_W-1:0] phi;
    logic [SIZE_W-1:0]  ssz;
    logic [SIZE_W-1:0]  dsz;
    logic [PORT_W:0]    sdiff;
    logic [PORT_W:0]    ddiff;
  } s1_t;

  typedef struct packed {
    logic [ERR_W-1:0]   err;
    logic [ADDR_W-1:0]  slo;
    logic [ADDR_W-1:0]  shi;
    logic [ADDR_W-1:0]  dlo;
    logic [ADDR_W-1:0]  dhi;
    logic [PROTO_W-1:0] plo;
    logic [PROTO_W-1:0] phi;
    logic [SIZE_W-1:0]  ssz;
    logic [SIZE_W-1:0]  dsz;
    logic [SIZE_W-1:0]  spsz;
    logic [SIZE_W-1:0]  dpsz;
    logic               ssmall;
    logic               dsmall;
  } s2_t;

  thr_t    thr;
  logic    v1, v2, v3;
  logic    ready1, ready2, ready3;
  s1_t     s1, s1_next;
  s2_t     s2, s2_next;
  result_t res, res_next;

  crp_cfg u_cfg (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .thr (thr)
  );

  assign ready3     = !v3 || result.ready;
  assign ready2     = !v2 || ready3;
  assign ready1     = !v1 || ready2;
  assign rule.ready = ready1;

  // stage 1: prefix to range, protocol, port differences
  always_comb begin
    s1_next = '0;
    if (rule.payload.src_prefix_len > MAX_PLEN) begin
      s1_next.err = ERR_SRC;
    end else if (rule.payload.dst_prefix_len > MAX_PLEN) begin
      s1_next.err = ERR_DST;
    end else if (rule.payload.proto_match != PROTO_EXACT &&
                 rule.payload.proto_match != PROTO_ANY) begin
      s1_next.err = ERR_PROTO;
    end else begin
      s1_next.err = ERR_OK;
    end
    s1_next.slo = rule.payload.src_addr & prefix_keep(rule.payload.src_prefix_len);
    s1_next.shi = s1_next.slo + (ADDR_ALL >> rule.payload.src_prefix_len);
    s1_next.dlo = rule.payload.dst_addr & prefix_keep(rule.payload.dst_prefix_len);
    s1_next.dhi = s1_next.dlo + (ADDR_ALL >> rule.payload.dst_prefix_len);
    if (rule.payload.proto_match == PROTO_EXACT) begin
      s1_next.plo = rule.payload.proto_value;
      s1_next.phi = rule.payload.proto_value;
    end else begin
      s1_next.plo = '0;
      s1_next.phi = '1;
    end
    s1_next.ssz   = FULL_SIZE - rule.payload.src_prefix_len;
    s1_next.dsz   = FULL_SIZE - rule.payload.dst_prefix_len;
    s1_next.sdiff = {1'b0, rule.payload.sport_high} - {1'b0, rule.payload.sport_low};
    s1_next.ddiff = {1'b0, rule.payload.dport_high} - {1'b0, rule.payload.dport_low};
  end

  // stage 2: port sizes and threshold compares
  always_comb begin
    s2_next.err    = s1.err;
    s2_next.slo    = s1.slo;
    s2_next.shi    = s1.shi;
    s2_next.dlo    = s1.dlo;
    s2_next.dhi    = s1.dhi;
    s2_next.plo    = s1.plo;
    s2_next.phi    = s1.phi;
    s2_next.ssz    = s1.ssz;
    s2_next.dsz    = s1.dsz;
    s2_next.spsz   = s1.sdiff[PORT_W] ? FULL_SIZE : bit_len(s1.sdiff[PORT_W-1:0]);
    s2_next.dpsz   = s1.ddiff[PORT_W] ? FULL_SIZE : bit_len(s1.ddiff[PORT_W-1:0]);
    s2_next.ssmall = s1.ssz <= thr.src;
    s2_next.dsmall = s1.dsz <= thr.dst;
  end

  // stage 3: classify, clear everything but the error code on a malformed rule
  always_comb begin
    res_next = '0;
    res_next.error_code = s2.err;
    if (s2.err == ERR_OK) begin
      res_next.src_low    = s2.slo;
      res_next.src_high   = s2.shi;
      res_next.dst_low    = s2.dlo;
      res_next.dst_high   = s2.dhi;
      res_next.proto_low  = s2.plo;
      res_next.proto_high = s2.phi;
      res_next.src_size   = s2.ssz;
      res_next.dst_size   = s2.dsz;
      res_next.sport_size = s2.spsz;
      res_next.dport_size = s2.dpsz;
      if (s2.ssmall && s2.dsmall) begin
        res_next.subset_class = CLS_BOTH;
      end else if (s2.ssmall) begin
        res_next.subset_class = CLS_SRC;
      end else if (s2.dsmall) begin
        res_next.subset_class = CLS_DST;
      end else begin
        res_next.subset_class = CLS_BIG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= rule.valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) s1 <= s1_next;
    if (ready2) s2 <= s2_next;
    if (ready3) res <= res_next;
  end

  assign result.valid   = v3;
  assign result.payload = res;

  // a malformed rule carries no ranges, sizes or class
  a_err_clears: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.payload.error_code != ERR_OK |->
      result.payload.src_size == '0 && result.payload.dst_size == '0 &&
      result.payload.subset_class == CLS_BOTH && result.payload.src_high == '0)
    else $error("malformed rule result not cleared");

  // address span agrees with its size
  a_span_size: assert property (@(posedge clk) disable iff (rst)
    result.valid |->
      (result.payload.src_high - result.payload.src_low) ==
        (ADDR_ALL >> (FULL_SIZE - result.payload.src_size)) &&
      (result.payload.dst_high - result.payload.dst_low) ==
        (ADDR_ALL >> (FULL_SIZE - result.payload.dst_size)))
    else $error("address range and size disagree");

  // thresholds come out of reset at their default
  a_thr_reset: assert property (@(posedge clk)
    rst |=> thr.src == THR_RESET && thr.dst == THR_RESET)
    else $error("thresholds not at reset value");

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the classifier rule range partition block. Rules
// go in on the request channel with random gaps, and results come back under
// random stalls. Each accepted rule is run through a local model of the
// prefix-to-range, size and subset logic. Each result is compared field by
// field, in order, with the oldest prediction. Threshold registers are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic clk;
  logic rst;

  crp_rule_if   rule_ch();
  crp_result_if result_ch();
  crp_cfg_if    cfg_ch();

  classifier_rule_range_partition u_dut (
    .clk    (clk),
    .rst    (rst),
    .rule   (rule_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  result_t          pending_ranges[$];
  logic [THR_W-1:0] src_thr;
  logic [THR_W-1:0] dst_thr;
  logic             steady;
  int               error_count;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // ceiling log2 of (hi - lo + 1) modulo 2^32, full range gives 32
  function automatic logic [SIZE_W-1:0] range_bits(input logic [ADDR_W-1:0] lo,
                                                   input logic [ADDR_W-1:0] hi);
    logic [ADDR_W-1:0] span;
    logic [63:0]       count;
    logic [SIZE_W-1:0] n;
    span = hi - lo;
    if (span == ADDR_ALL) begin
      return FULL_SIZE;
    end
    count = 64'(span) + 64'd1;
    n = '0;
    while ((64'd1 << n) < count) n++;
    return n;
  endfunction

  function automatic logic prefix_to_range(input logic [ADDR_W-1:0] addr,
                                           input logic [PLEN_W-1:0] plen,
                                           output logic [ADDR_W-1:0] lo,
                                           output logic [ADDR_W-1:0] hi);
    logic [ADDR_W-1:0] keep;
    logic [63:0]       span;
    lo = '0;
    hi = '0;
    if (plen == '0) begin
      hi = ADDR_ALL;
      return 1'b1;
    end
    if (plen > MAX_PLEN) begin
      return 1'b0;
    end
    if (plen <= 6'd8) begin
      keep = 32'hFF000000;
    end else if (plen <= 6'd16) begin
      keep = 32'hFFFF0000;
    end else if (plen <= 6'd24) begin
      keep = 32'hFFFFFF00;
    end else begin
      keep = ADDR_ALL;
    end
    lo = addr & keep;
    span = (64'd1 << (32 - int'(plen))) - 64'd1;
    hi = lo + span[ADDR_W-1:0];
    return 1'b1;
  endfunction

  function automatic result_t partition_rule(input rule_t r);
    result_t           res;
    logic [ADDR_W-1:0] slo, shi, dlo, dhi;
    logic              src_fits, dst_fits;
    res = '0;
    if (!prefix_to_range(r.src_addr, r.src_prefix_len, slo, shi)) begin
      res.error_code = ERR_SRC;
      return res;
    end
    if (!prefix_to_range(r.dst_addr, r.dst_prefix_len, dlo, dhi)) begin
      res.error_code = ERR_DST;
      return res;
    end
    if (r.proto_match == PROTO_EXACT) begin
      res.proto_low  = r.proto_value;
      res.proto_high = r.proto_value;
    end else if (r.proto_match == PROTO_ANY) begin
      res.proto_low  = 8'h00;
      res.proto_high = 8'hFF;
    end else begin
      res.error_code = ERR_PROTO;
      return res;
    end
    res.src_low    = slo;
    res.src_high   = shi;
    res.dst_low    = dlo;
    res.dst_high   = dhi;
    res.src_size   = range_bits(slo, shi);
    res.dst_size   = range_bits(dlo, dhi);
    res.sport_size = range_bits({16'h0, r.sport_low}, {16'h0, r.sport_high});
    res.dport_size = range_bits({16'h0, r.dport_low}, {16'h0, r.dport_high});
    src_fits = res.src_size <= src_thr;
    dst_fits = res.dst_size <= dst_thr;
    if (src_fits && dst_fits) begin
      res.subset_class = CLS_BOTH;
    end else if (src_fits) begin
      res.subset_class = CLS_SRC;
    end else if (dst_fits) begin
      res.subset_class = CLS_DST;
    end else begin
      res.subset_class = CLS_BIG;
    end
    res.error_code = ERR_OK;
    return res;
  endfunction

  function automatic rule_t make_rule(input logic [ADDR_W-1:0] saddr,
                                      input logic [PLEN_W-1:0] splen,
                                      input logic [ADDR_W-1:0] daddr,
                                      input logic [PLEN_W-1:0] dplen,
                                      input logic [PORT_W-1:0] spl, sph, dpl, dph,
                                      input logic [PROTO_W-1:0] pval, pmask);
    rule_t r;
    r.src_addr       = saddr;
    r.src_prefix_len = splen;
    r.dst_addr       = daddr;
    r.dst_prefix_len = dplen;
    r.sport_low      = spl;
    r.sport_high     = sph;
    r.dport_low      = dpl;
    r.dport_high     = dph;
    r.proto_value    = pval;
    r.proto_match    = pmask;
    return r;
  endfunction

  function automatic logic [PLEN_W-1:0] random_plen();
    if ($urandom_range(0, 99) < 90) begin
      return PLEN_W'($urandom_range(0, 32));
    end
    return PLEN_W'($urandom_range(33, 63));
  endfunction

  function automatic logic [PORT_W-1:0] random_port_high(input logic [PORT_W-1:0] lo);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      return lo + PORT_W'(($urandom() & 32'hFFFF) >> $urandom_range(0, 16));
    end else if (pick < 60) begin
      return lo;
    end
    return PORT_W'($urandom());
  endfunction

  function automatic rule_t random_rule();
    rule_t r;
    int    pick;
    r.src_addr       = $urandom();
    r.dst_addr       = $urandom();
    r.src_prefix_len = random_plen();
    r.dst_prefix_len = random_plen();
    r.sport_low      = PORT_W'($urandom());
    r.sport_high     = random_port_high(r.sport_low);
    r.dport_low      = PORT_W'($urandom());
    r.dport_high     = random_port_high(r.dport_low);
    r.proto_value    = PROTO_W'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.proto_match = PROTO_EXACT;
    end else if (pick < 90) begin
      r.proto_match = PROTO_ANY;
    end else begin
      r.proto_match = PROTO_W'($urandom());
    end
    return r;
  endfunction

  // called and returns at a falling edge
  task automatic send_rule(input rule_t r);
    while (!steady && $urandom_range(0, 99) < 15) begin
      rule_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rule_ch.valid   <= 1'b1;
    rule_ch.payload <= r;
    do @(posedge clk); while (!rule_ch.ready);
    pending_ranges.push_back(partition_rule(r));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    rule_ch.valid <= 1'b0;
    while (pending_ranges.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [THR_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_SRC_THR) begin
      src_thr = value;
    end else if (idx == REG_DST_THR) begin
      dst_thr = value;
    end
    @(negedge clk);
  endtask

  // spare indexes are written too and must leave the thresholds alone
  task automatic set_thresholds(input logic [THR_W-1:0] src_value,
                                input logic [THR_W-1:0] dst_value);
    wait_idle();
    write_register(REG_SRC_THR, src_value);
    write_register(REG_SPARE_A, THR_W'($urandom()));
    write_register(REG_DST_THR, dst_value);
    write_register(REG_SPARE_B, THR_W'($urandom()));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [ADDR_W-1:0] exp_val,
                             input logic [ADDR_W-1:0] got_val);
    if (exp_val !== got_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      error_count++;
    end
  endtask

  task automatic check_result(input result_t exp_res, input result_t got_res);
    check_field("src_low", exp_res.src_low, got_res.src_low);
    check_field("src_high", exp_res.src_high, got_res.src_high);
    check_field("dst_low", exp_res.dst_low, got_res.dst_low);
    check_field("dst_high", exp_res.dst_high, got_res.dst_high);
    check_field("proto_low", ADDR_W'(exp_res.proto_low), ADDR_W'(got_res.proto_low));
    check_field("proto_high", ADDR_W'(exp_res.proto_high), ADDR_W'(got_res.proto_high));
    check_field("src_size", ADDR_W'(exp_res.src_size), ADDR_W'(got_res.src_size));
    check_field("dst_size", ADDR_W'(exp_res.dst_size), ADDR_W'(got_res.dst_size));
    check_field("sport_size", ADDR_W'(exp_res.sport_size), ADDR_W'(got_res.sport_size));
    check_field("dport_size", ADDR_W'(exp_res.dport_size), ADDR_W'(got_res.dport_size));
    check_field("subset_class", ADDR_W'(exp_res.subset_class),
                ADDR_W'(got_res.subset_class));
    check_field("error_code", ADDR_W'(exp_res.error_code), ADDR_W'(got_res.error_code));
  endtask

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_ranges.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        check_result(pending_ranges.pop_front(), result_ch.payload);
      end
    end
  end

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= steady || ($urandom_range(0, 99) >= 15);
    end
  end

  task automatic test_directed_rules();
    send_rule(make_rule('0, 6'd0, '0, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, PROTO_ANY));
    send_rule(make_rule(ADDR_ALL, 6'd32, ADDR_ALL, 6'd32, 16'd0, 16'hFFFF,
                        16'hFFFF, 16'd0, 8'hFF, PROTO_EXACT));
    send_rule(make_rule(32'hC0A80164, 6'd8, 32'h0A0B0C0D, 6'd9, 16'd80, 16'd80,
                        16'd1024, 16'hFFFF, 8'd6, PROTO_EXACT));
    send_rule(make_rule(32'hAC10FE01, 6'd16, 32'h8F7E6D5C, 6'd17, 16'd0, 16'd1,
                        16'd0, 16'd2, 8'd17, PROTO_EXACT));
    send_rule(make_rule(32'h12345678, 6'd24, 32'h9ABCDEF0, 6'd25, 16'd100, 16'd355,
                        16'd1, 16'd0, 8'd0, PROTO_EXACT));
    send_rule(make_rule(ADDR_ALL, 6'd1, 32'h55AA55AA, 6'd31, 16'hFFFF, 16'hFFFE,
                        16'h8000, 16'hFFFF, 8'hAB, PROTO_ANY));
    // leading octets kept but the add carries past them
    send_rule(make_rule(32'hFFFFFFF0, 6'd20, 32'h00FFFF80, 6'd12, 16'd7, 16'd8,
                        16'd0, 16'h7FFF, 8'h80, PROTO_EXACT));
    send_rule(make_rule(32'h01020304, 6'd33, 32'h01020304, 6'd8, 16'd0, 16'd0,
                        16'd0, 16'd0, 8'd6, PROTO_EXACT));
    // both prefixes and mask bad, source wins
    send_rule(make_rule(32'hDEADBEEF, 6'd63, 32'hCAFEF00D, 6'd40, 16'd5, 16'd9,
                        16'd1, 16'd2, 8'd1, 8'h0F));
    send_rule(make_rule(32'h0A000000, 6'd8, 32'hFFFFFFFF, 6'd33, 16'd0, 16'hFFFF,
                        16'd0, 16'hFFFF, 8'd6, PROTO_EXACT));
    send_rule(make_rule(32'h0A000000, 6'd32, 32'h0B000000, 6'd63, 16'd1, 16'd1,
                        16'd1, 16'd1, 8'd6, 8'h01));
    send_rule(make_rule(32'h0A000000, 6'd24, 32'h0B000000, 6'd0, 16'd1, 16'd1,
                        16'd1, 16'd1, 8'd6, 8'h01));
    send_rule(make_rule(32'h0A000000, 6'd0, 32'h0B000000, 6'd32, 16'd1, 16'd1,
                        16'd1, 16'd1, 8'hFF, 8'hFE));
    send_rule(make_rule(32'h0A000000, 6'd1, 32'h0B000000, 6'd2, 16'd1, 16'd1,
                        16'd1, 16'd1, 8'h00, 8'h80));
    send_rule(make_rule(32'h80000000, 6'd2, ADDR_ALL, 6'd0, 16'h00FF, 16'h0100,
                        16'h1234, 16'h1233, 8'h00, PROTO_EXACT));
    send_rule(make_rule(32'h7FFFFFFF, 6'd16, 32'h00000001, 6'd24, 16'hFFFF, 16'hFFFF,
                        16'd0, 16'h8000, 8'h7F, PROTO_ANY));
    wait_idle();
  endtask

  task automatic threshold_phase(input logic [THR_W-1:0] src_value,
                                 input logic [THR_W-1:0] dst_value);
    set_thresholds(src_value, dst_value);
    repeat (20) send_rule(random_rule());
  endtask

  task automatic test_threshold_sweep();
    threshold_phase(6'd0, 6'd0);
    threshold_phase(6'd32, 6'd32);
    threshold_phase(6'd63, 6'd63);
    threshold_phase(6'd33, 6'd1);
    threshold_phase(6'd5, 6'd40);
    threshold_phase(6'd31, 6'd24);
    threshold_phase(THR_RESET, THR_RESET);
    wait_idle();
  endtask

  task automatic test_random_rules();
    for (int n = 0; n < 340; n++) begin
      if (n % 100 == 0) begin
        set_thresholds(THR_W'($urandom_range(0, 40)), THR_W'($urandom_range(0, 40)));
      end
      steady = (n >= 200 && n < 300);
      send_rule(random_rule());
    end
    steady = 1'b0;
    wait_idle();
  endtask

  initial begin
    rule_ch.valid   = 1'b0;
    rule_ch.payload = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_SRC_THR;
    cfg_ch.data     = '0;
    steady          = 1'b0;
    error_count     = 0;
    src_thr         = THR_RESET;
    dst_thr         = THR_RESET;
    rst             = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_rules();
    test_threshold_sweep();
    test_random_rules();
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_ranges.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
